>>> design/rcds_pkg.sv
package rcds_pkg;

    // Fixed field widths of the digit channel and the base input.
    localparam int DIGIT_W    = 4;
    localparam int BASE_W     = 4;

    // Number of quotient bits produced by the divider in one cycle.
    localparam int CHUNK_BITS = 8;

    // Legal radix range; bases outside it are clamped to the nearest end.
    localparam logic [BASE_W-1:0] BASE_MIN = 4'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 4'd9;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ZERO,
        S_DIV,
        S_POP
    } t_state;

    // Status handed from the divider to the sequencer.
    typedef struct packed {
        logic               done;
        logic               quot_zero;
        logic [DIGIT_W-1:0] digit;
    } t_div_status;

endpackage

>>> design/rcds_stack_mem.sv
module rcds_stack_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [rcds_pkg::DIGIT_W-1:0]  i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [rcds_pkg::DIGIT_W-1:0]  o_rdata
);

    logic [rcds_pkg::DIGIT_W-1:0] r_mem [DEPTH];
    logic [rcds_pkg::DIGIT_W-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rcds_divider.sv
module rcds_divider #(
    parameter int VALUE_BITS = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic                         i_run,
    input  logic [VALUE_BITS-1:0]        i_value,
    input  logic [rcds_pkg::BASE_W-1:0]  i_base,
    output rcds_pkg::t_div_status        o_status
);

    localparam int CHUNK  = rcds_pkg::CHUNK_BITS;
    localparam int NCHUNK = (VALUE_BITS + CHUNK - 1) / CHUNK;
    localparam int PW     = NCHUNK * CHUNK;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    logic [PW-1:0]                    r_work;
    logic [rcds_pkg::DIGIT_W-1:0]     r_rem;
    logic [rcds_pkg::BASE_W-1:0]      r_base;
    logic [CW-1:0]                    r_cnt;

    logic [PW-1:0]                    n_work;
    logic [rcds_pkg::DIGIT_W-1:0]     n_rem;
    logic [CHUNK-1:0]                 qbits;
    logic [rcds_pkg::BASE_W-1:0]      base_clamped;
    logic                             last_chunk;

    // Clamp the radix into the supported range.
    always_comb begin
        if (i_base < rcds_pkg::BASE_MIN) begin
            base_clamped = rcds_pkg::BASE_MIN;
        end else if (i_base > rcds_pkg::BASE_MAX) begin
            base_clamped = rcds_pkg::BASE_MAX;
        end else begin
            base_clamped = i_base;
        end
    end

    // Long division of one chunk, most significant bit first. The running
    // remainder stays below the base, so each step is a narrow compare and
    // subtract.
    always_comb begin
        logic [rcds_pkg::DIGIT_W:0] acc;
        logic [CHUNK-1:0]           chunk;
        chunk = r_work[PW-1 -: CHUNK];
        n_rem = r_rem;
        qbits = '0;
        for (int k = CHUNK - 1; k >= 0; k--) begin
            acc = {n_rem, chunk[k]};
            if (acc >= {1'b0, r_base}) begin
                acc      = acc - {1'b0, r_base};
                qbits[k] = 1'b1;
            end
            n_rem = acc[rcds_pkg::DIGIT_W-1:0];
        end
        // The dividend shifts out at the top while the quotient shifts in
        // at the bottom, so after the last chunk the word holds the quotient.
        n_work = (r_work << CHUNK) | PW'(qbits);
    end

    assign last_chunk         = (r_cnt == CW'(NCHUNK - 1));
    assign o_status.done      = i_run && last_chunk;
    assign o_status.digit     = n_rem;
    assign o_status.quot_zero = (n_work == '0);

    // Chunk counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_run) begin
            if (last_chunk) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // Dividend, remainder and base.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_work <= PW'(i_value);
            r_rem  <= '0;
            r_base <= base_clamped;
        end else if (i_run) begin
            r_work <= n_work;
            if (last_chunk) begin
                r_rem <= '0;
            end else begin
                r_rem <= n_rem;
            end
        end
    end

endmodule

>>> design/radix_conversion_digit_stack_top.sv
// Operation: for each digit the divider works through the value chunk by chunk, and the digit
// is pushed on the stack memory; the stack memory is then popped to the output.
// A zero value gives its single result via the output register; an output stall can delay it.
// Throughput: one item at a time; the next input is taken once the last digit read is issued.
// The divider retires 8 quotient bits per cycle; pops are paced by the memory read latency.
// Reset is synchronous and active low; it clears the sequencer, stack level and output valid.
module radix_conversion_digit_stack_top #(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_BITS  = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [VALUE_BITS-1:0]         i_value,
    input  logic [rcds_pkg::BASE_W-1:0]   i_base,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rcds_pkg::DIGIT_W-1:0]  o_digit,
    output logic                          o_last,
    output logic                          o_empty_res
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    rcds_pkg::t_state       r_state;
    rcds_pkg::t_state       n_state;
    logic [LW-1:0]          r_level;
    logic                   r_rd_pend;
    logic                   r_pend_last;
    logic                   r_out_valid;
    logic [rcds_pkg::DIGIT_W-1:0] r_out_digit;
    logic                   r_out_last;
    logic                   r_out_empty;

    rcds_pkg::t_div_status  div_status;
    logic [rcds_pkg::DIGIT_W-1:0] rd_data;
    logic [LW-1:0]          level_dec;
    logic                   in_xfer;
    logic                   out_free;
    logic                   div_load;
    logic                   div_run;
    logic                   mem_we;
    logic                   rd_issue;
    logic                   zero_load;
    logic                   stack_full_next;

    assign in_xfer         = i_valid && !o_stall;
    assign level_dec       = r_level - LW'(1);
    assign stack_full_next = (r_level == LW'(STACK_DEPTH - 1));

    // The output register is free for new data at the next edge when no read
    // is in flight and it is empty or being taken now.
    assign out_free = !r_rd_pend && (!r_out_valid || !i_stall);

    rcds_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (div_load),
        .i_run    (div_run),
        .i_value  (i_value),
        .i_base   (i_base),
        .o_status (div_status)
    );

    rcds_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_level[AW-1:0]),
        .i_wdata (div_status.digit),
        .i_re    (rd_issue),
        .i_raddr (level_dec[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcds_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (i_value == '0) begin
                        n_state = rcds_pkg::S_ZERO;
                    end else begin
                        n_state = rcds_pkg::S_DIV;
                    end
                end
            end
            rcds_pkg::S_ZERO: begin
                if (out_free) begin
                    n_state = rcds_pkg::S_IDLE;
                end
            end
            rcds_pkg::S_DIV: begin
                if (div_status.done && (div_status.quot_zero || stack_full_next)) begin
                    n_state = rcds_pkg::S_POP;
                end
            end
            rcds_pkg::S_POP: begin
                if (out_free && (r_level == LW'(1))) begin
                    n_state = rcds_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcds_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_stall   = 1'b1;
        div_load  = 1'b0;
        div_run   = 1'b0;
        mem_we    = 1'b0;
        rd_issue  = 1'b0;
        zero_load = 1'b0;
        case (r_state)
            rcds_pkg::S_IDLE: begin
                o_stall  = 1'b0;
                div_load = i_valid;
            end
            rcds_pkg::S_ZERO: begin
                zero_load = out_free;
            end
            rcds_pkg::S_DIV: begin
                div_run = 1'b1;
                mem_we  = div_status.done;
            end
            rcds_pkg::S_POP: begin
                rd_issue = out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // State, stack level and read tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcds_pkg::S_IDLE;
            r_level     <= '0;
            r_rd_pend   <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= rd_issue;
            r_pend_last <= rd_issue && (r_level == LW'(1));
            if (in_xfer) begin
                r_level <= '0;
            end else if (mem_we) begin
                r_level <= r_level + LW'(1);
            end else if (rd_issue) begin
                r_level <= level_dec;
            end
        end
    end

    // Output register: loaded from the stack read or with the empty result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_rd_pend || zero_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_out_digit <= rd_data;
            r_out_last  <= r_pend_last;
            r_out_empty <= 1'b0;
        end else if (zero_load) begin
            r_out_digit <= '0;
            r_out_last  <= 1'b1;
            r_out_empty <= 1'b1;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_digit     = r_out_digit;
    assign o_last      = r_out_last;
    assign o_empty_res = r_out_empty;

`ifndef SYNTHESIS
    // The stack never holds more digits than it has entries.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    // A read in flight always lands in an empty output register.
    a_pend_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> !r_out_valid)
        else $error("stack read overwrites a waiting result");

    // Popping only happens with digits on the stack.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcds_pkg::S_POP) |-> (r_level != '0))
        else $error("pop from an empty stack");

    // The empty result is always the sole and final result of its item.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_res) |-> (o_last && (o_digit == '0)))
        else $error("empty result not flagged as last");
`endif

endmodule
